/* rtl/core/qau_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit package
// Payload types, operation codes and Q4.28 rounding and clipping helpers.
// ----------------------------------------------------------------------------
package qau_pkg;

	localparam int QW   = 32;          // Q4.28 word
	localparam int FRAC = 28;
	localparam int OPW  = QW + 1;      // operand, holds a negated minimum
	localparam int PRW  = 2 * OPW;     // full product
	localparam int RNW  = PRW - FRAC;  // rounded product
	localparam int SUMW = 41;          // sum of four rounded products, doubled

	typedef enum logic [1:0] {
		FN_MUL  = 2'd0,
		FN_ROT  = 2'd1,
		FN_DCM  = 2'd2,
		FN_NONE = 2'd3
	} func_t;

	typedef logic [OPW-1:0] op_t;
	typedef op_t [3:0] quat_t;
	typedef logic [PRW-1:0] prod_t;
	typedef prod_t [15:0] prods_t;

	typedef struct packed {
		func_t           func;
		logic signed [QW-1:0] a_w;
		logic signed [QW-1:0] a_x;
		logic signed [QW-1:0] a_y;
		logic signed [QW-1:0] a_z;
		logic signed [QW-1:0] b_w;
		logic signed [QW-1:0] b_x;
		logic signed [QW-1:0] b_y;
		logic signed [QW-1:0] b_z;
		logic signed [QW-1:0] scale;
	} cmd_t;

	typedef struct packed {
		logic signed [QW-1:0] r0;
		logic signed [QW-1:0] r1;
		logic signed [QW-1:0] r2;
		logic signed [QW-1:0] r3;
		logic signed [QW-1:0] r4;
		logic signed [QW-1:0] r5;
		logic signed [QW-1:0] r6;
		logic signed [QW-1:0] r7;
		logic signed [QW-1:0] r8;
		logic                 saturated;
	} res_t;

	// fields of a request still needed after the first product layer
	typedef struct packed {
		func_t           func;
		logic [QW-1:0]   scale;
		logic [QW-1:0]   a_w;
		logic [QW-1:0]   a_x;
		logic [QW-1:0]   a_y;
		logic [QW-1:0]   a_z;
	} side_t;

	// round half up, then floor by 2^FRAC
	function automatic logic signed [RNW-1:0] rnd(input prod_t p);
		logic signed [PRW-1:0] t;
		t = $signed(p) + $signed(PRW'(1) << (FRAC - 1));
		return RNW'(t >>> FRAC);
	endfunction

	function automatic logic ovf(input logic signed [SUMW-1:0] v);
		return v[SUMW-1:QW-1] != {(SUMW-QW+1){v[QW-1]}};
	endfunction

	function automatic logic [QW-1:0] clip32(input logic signed [SUMW-1:0] v);
		logic [QW-1:0] r;
		if (!ovf(v))
			r = v[QW-1:0];
		else if (v[SUMW-1])
			r = {1'b1, {(QW-1){1'b0}}};
		else
			r = {1'b0, {(QW-1){1'b1}}};
		return r;
	endfunction

	function automatic op_t sext(input logic [QW-1:0] x);
		return {x[QW-1], x};
	endfunction

	function automatic op_t neg(input logic [QW-1:0] x);
		return ({x[QW-1], x} ^ {OPW{1'b1}}) + OPW'(1);
	endfunction

endpackage

/* rtl/core/qau_prod.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Product array
// All sixteen cross products p[i]*q[j], registered.
// ----------------------------------------------------------------------------
module qau_prod (
	input  logic             clk,
	input  logic             en,
	input  qau_pkg::quat_t   p,
	input  qau_pkg::quat_t   q,
	output qau_pkg::prods_t  prods_s
);

	logic signed [qau_pkg::PRW-1:0] pr [16];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				pr[4*i+j] = $signed(p[i]) * $signed(q[j]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 16; k++) begin
				prods_s[k] <= pr[k];
			end
		end
	end

endmodule

/* rtl/core/qau_comb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Product combiner
// Rounds the cross products and forms the Hamilton product or the
// direction cosine matrix, clipped to Q4.28, registered.
// ----------------------------------------------------------------------------
module qau_comb (
	input  logic             clk,
	input  logic             en,
	input  qau_pkg::func_t   func,
	input  qau_pkg::prods_t  prods,
	output qau_pkg::res_t    res_s
);

	logic signed [qau_pkg::RNW-1:0]  rp [4][4];
	logic signed [qau_pkg::SUMW-1:0] h [4];
	logic signed [qau_pkg::SUMW-1:0] m [9];
	qau_pkg::res_t                   nxt;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				rp[i][j] = qau_pkg::rnd(prods[4*i+j]);
			end
		end

		h[0] = rp[0][0] - rp[1][1] - rp[2][2] - rp[3][3];
		h[1] = rp[0][1] + rp[1][0] + rp[2][3] - rp[3][2];
		h[2] = rp[0][2] - rp[1][3] + rp[2][0] + rp[3][1];
		h[3] = rp[0][3] + rp[1][2] - rp[2][1] + rp[3][0];

		// q = p here, so rp[i][j] is a_i*a_j
		m[0] = rp[0][0] + rp[1][1] - rp[2][2] - rp[3][3];
		m[1] = (qau_pkg::SUMW'(rp[1][2]) - qau_pkg::SUMW'(rp[0][3])) <<< 1;
		m[2] = (qau_pkg::SUMW'(rp[1][3]) + qau_pkg::SUMW'(rp[0][2])) <<< 1;
		m[3] = (qau_pkg::SUMW'(rp[1][2]) + qau_pkg::SUMW'(rp[0][3])) <<< 1;
		m[4] = rp[0][0] - rp[1][1] + rp[2][2] - rp[3][3];
		m[5] = (qau_pkg::SUMW'(rp[2][3]) - qau_pkg::SUMW'(rp[0][1])) <<< 1;
		m[6] = (qau_pkg::SUMW'(rp[1][3]) - qau_pkg::SUMW'(rp[0][2])) <<< 1;
		m[7] = (qau_pkg::SUMW'(rp[2][3]) + qau_pkg::SUMW'(rp[0][1])) <<< 1;
		m[8] = rp[0][0] - rp[1][1] - rp[2][2] + rp[3][3];

		nxt = '0;
		unique case (func)
			qau_pkg::FN_MUL, qau_pkg::FN_ROT: begin
				nxt.r0 = qau_pkg::clip32(h[0]);
				nxt.r1 = qau_pkg::clip32(h[1]);
				nxt.r2 = qau_pkg::clip32(h[2]);
				nxt.r3 = qau_pkg::clip32(h[3]);
				nxt.saturated = qau_pkg::ovf(h[0]) | qau_pkg::ovf(h[1])
					| qau_pkg::ovf(h[2]) | qau_pkg::ovf(h[3]);
			end
			qau_pkg::FN_DCM: begin
				nxt.r0 = qau_pkg::clip32(m[0]);
				nxt.r1 = qau_pkg::clip32(m[1]);
				nxt.r2 = qau_pkg::clip32(m[2]);
				nxt.r3 = qau_pkg::clip32(m[3]);
				nxt.r4 = qau_pkg::clip32(m[4]);
				nxt.r5 = qau_pkg::clip32(m[5]);
				nxt.r6 = qau_pkg::clip32(m[6]);
				nxt.r7 = qau_pkg::clip32(m[7]);
				nxt.r8 = qau_pkg::clip32(m[8]);
				nxt.saturated = qau_pkg::ovf(m[0]) | qau_pkg::ovf(m[1]) | qau_pkg::ovf(m[2])
					| qau_pkg::ovf(m[3]) | qau_pkg::ovf(m[4]) | qau_pkg::ovf(m[5])
					| qau_pkg::ovf(m[6]) | qau_pkg::ovf(m[7]) | qau_pkg::ovf(m[8]);
			end
			default: begin
				nxt = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s <= nxt;
		end
	end

endmodule

/* rtl/core/qau_scale.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scale stage
// Multiplies the rotated vector by the scale factor; the products are
// registered and then rounded and clipped.
// ----------------------------------------------------------------------------
module qau_scale (
	input  logic                        clk,
	input  logic                        en,
	input  logic [qau_pkg::QW-1:0]      scale,
	input  logic [qau_pkg::QW-1:0]      vx,
	input  logic [qau_pkg::QW-1:0]      vy,
	input  logic [qau_pkg::QW-1:0]      vz,
	output logic [qau_pkg::QW-1:0]      rx,
	output logic [qau_pkg::QW-1:0]      ry,
	output logic [qau_pkg::QW-1:0]      rz,
	output logic                        sat
);

	logic signed [qau_pkg::PRW-1:0]  pr [3];
	qau_pkg::prod_t                  prod_s5 [3];
	logic signed [qau_pkg::SUMW-1:0] v [3];

	always_comb begin
		pr[0] = $signed(vx) * $signed(scale);
		pr[1] = $signed(vy) * $signed(scale);
		pr[2] = $signed(vz) * $signed(scale);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				prod_s5[k] <= pr[k];
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			v[k] = qau_pkg::SUMW'(qau_pkg::rnd(prod_s5[k]));
		end
		rx  = qau_pkg::clip32(v[0]);
		ry  = qau_pkg::clip32(v[1]);
		rz  = qau_pkg::clip32(v[2]);
		sat = qau_pkg::ovf(v[0]) | qau_pkg::ovf(v[1]) | qau_pkg::ovf(v[2]);
	end

endmodule

/* rtl/core/quaternion_arithmetic_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit
// Quaternion product, vector rotation and quaternion to matrix in Q4.28.
// ----------------------------------------------------------------------------
// The unit takes one request per cycle while cmd_ready is high. The pipeline
// is three multiply layers (first product, product with the conjugate,
// scale), each followed by a round-and-clip stage; a product or matrix
// request rides through the later stages unchanged. When the output
// register holds a result that is not taken, the whole pipeline holds and
// cmd_ready falls; nothing is dropped or repeated.
module quaternion_arithmetic_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  qau_pkg::cmd_t  cmd,
	output logic           res_valid,
	input  logic           res_ready,
	output qau_pkg::res_t  res
);

	logic            en;
	logic            vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	qau_pkg::side_t  side_in, side_s1, side_s2, side_s3, side_s4, side_s5;
	qau_pkg::quat_t  p1, q1, p2, q2;
	qau_pkg::prods_t prods_s1, prods_s3;
	qau_pkg::res_t   first_s2, first_s3, first_s4, first_s5, t2_s4;
	logic            sat_s5;
	logic [qau_pkg::QW-1:0] rx, ry, rz;
	logic            sat_sc;
	qau_pkg::res_t   res_s6, fin;

	assign en        = !vld_s6 || res_ready;
	assign cmd_ready = en;
	assign res_valid = vld_s6;
	assign res       = res_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= cmd_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// first layer operands: b, the pure vector, or a itself for the matrix
	always_comb begin
		side_in.func  = cmd.func;
		side_in.scale = cmd.scale;
		side_in.a_w   = cmd.a_w;
		side_in.a_x   = cmd.a_x;
		side_in.a_y   = cmd.a_y;
		side_in.a_z   = cmd.a_z;

		p1[0] = qau_pkg::sext(cmd.a_w);
		p1[1] = qau_pkg::sext(cmd.a_x);
		p1[2] = qau_pkg::sext(cmd.a_y);
		p1[3] = qau_pkg::sext(cmd.a_z);
		unique case (cmd.func)
			qau_pkg::FN_ROT: begin
				q1[0] = '0;
				q1[1] = qau_pkg::sext(cmd.b_x);
				q1[2] = qau_pkg::sext(cmd.b_y);
				q1[3] = qau_pkg::sext(cmd.b_z);
			end
			qau_pkg::FN_DCM: begin
				q1 = p1;
			end
			default: begin
				q1[0] = qau_pkg::sext(cmd.b_w);
				q1[1] = qau_pkg::sext(cmd.b_x);
				q1[2] = qau_pkg::sext(cmd.b_y);
				q1[3] = qau_pkg::sext(cmd.b_z);
			end
		endcase
	end

	qau_prod u_prod1 (
		.clk     (clk),
		.en      (en),
		.p       (p1),
		.q       (q1),
		.prods_s (prods_s1)
	);

	qau_comb u_comb1 (
		.clk   (clk),
		.en    (en),
		.func  (side_s1.func),
		.prods (prods_s1),
		.res_s (first_s2)
	);

	// second layer: a*v times the exact conjugate of a
	always_comb begin
		p2[0] = qau_pkg::sext(first_s2.r0);
		p2[1] = qau_pkg::sext(first_s2.r1);
		p2[2] = qau_pkg::sext(first_s2.r2);
		p2[3] = qau_pkg::sext(first_s2.r3);
		q2[0] = qau_pkg::sext(side_s2.a_w);
		q2[1] = qau_pkg::neg(side_s2.a_x);
		q2[2] = qau_pkg::neg(side_s2.a_y);
		q2[3] = qau_pkg::neg(side_s2.a_z);
	end

	qau_prod u_prod2 (
		.clk     (clk),
		.en      (en),
		.p       (p2),
		.q       (q2),
		.prods_s (prods_s3)
	);

	qau_comb u_comb2 (
		.clk   (clk),
		.en    (en),
		.func  (qau_pkg::FN_MUL),
		.prods (prods_s3),
		.res_s (t2_s4)
	);

	qau_scale u_scale (
		.clk   (clk),
		.en    (en),
		.scale (side_s4.scale),
		.vx    (t2_s4.r1),
		.vy    (t2_s4.r2),
		.vz    (t2_s4.r3),
		.rx    (rx),
		.ry    (ry),
		.rz    (rz),
		.sat   (sat_sc)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1  <= side_in;
			side_s2  <= side_s1;
			side_s3  <= side_s2;
			side_s4  <= side_s3;
			side_s5  <= side_s4;
			first_s3 <= first_s2;
			first_s4 <= first_s3;
			first_s5 <= first_s4;
			sat_s5   <= first_s4.saturated | t2_s4.saturated;
			res_s6   <= fin;
		end
	end

	always_comb begin
		fin = first_s5;
		if (side_s5.func == qau_pkg::FN_ROT) begin
			fin           = '0;
			fin.r0        = rx;
			fin.r1        = ry;
			fin.r2        = rz;
			fin.saturated = sat_s5 | sat_sc;
		end
	end

endmodule
